// File: hw/rtl/sqlkl_pkg.sv
// Shared types, codes and keyword helpers for the SQL keyword lexer.
package sqlkl_pkg;

  // Lexer mode held between bytes.
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_INTEGER,
    MODE_IDENT,
    MODE_SKIP
  } lex_mode_t;

  // Token types reported at the end of each token.
  typedef enum logic [3:0] {
    KIND_STAR       = 4'd0,
    KIND_COMMA      = 4'd1,
    KIND_SEMICOLON  = 4'd2,
    KIND_LPAREN     = 4'd3,
    KIND_RPAREN     = 4'd4,
    KIND_STRING     = 4'd5,
    KIND_INTEGER    = 4'd6,
    KIND_IDENT      = 4'd7,
    KIND_SELECT     = 4'd8,
    KIND_FROM       = 4'd9,
    KIND_INSERT     = 4'd10,
    KIND_INTO       = 4'd11,
    KIND_VALUES     = 4'd12
  } token_kind_t;

  // Error codes.
  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_INVALID_CHAR = 2'd1,
    ERR_OPEN_STRING  = 2'd2
  } err_code_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  lexeme_byte;
    logic        lexeme_byte_valid;
    logic        token_complete;
    token_kind_t token_kind;
    err_code_t   error_code;
    logic        statement_finished;
    logic        last_of_run;
  } res_t;

  localparam logic [4:0] ALL_KEYWORDS = 5'b11111;
  localparam logic [7:0] QUOTE_CH     = 8'h27;

  // Keyword text, entry 0 is SELECT; short words are padded with spaces.
  localparam logic [4:0][47:0] KW_TEXT = {"VALUES", "INTO  ", "INSERT", "FROM  ", "SELECT"};
  localparam logic [4:0][2:0]  KW_LEN  = {3'd6, 3'd4, 3'd6, 3'd4, 3'd6};

  // Builds a result; byte and kind read as zero when they carry nothing.
  function automatic res_t make_res(logic [7:0] b, logic v, logic d, token_kind_t k,
                                    err_code_t e);
    res_t r;
    r.lexeme_byte        = v ? b : 8'h00;
    r.lexeme_byte_valid  = v;
    r.token_complete     = d;
    r.token_kind         = d ? k : KIND_STAR;
    r.error_code         = e;
    r.statement_finished = 1'b0;
    r.last_of_run        = 1'b0;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_ident_start(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || (b == 8'h5F);
  endfunction

  function automatic logic is_ident_part(logic [7:0] b);
    return is_ident_start(b) || is_digit(b);
  endfunction

  // Character of keyword k at position p.
  function automatic logic [7:0] kw_char(logic [2:0] k, logic [2:0] p);
    logic [47:0] w;
    w = KW_TEXT[k] << {p, 3'b000};
    return w[47:40];
  endfunction

  // Drops every keyword that does not match this character at this position.
  function automatic logic [4:0] advance_cand(logic [2:0] pos, logic [4:0] cand,
                                              logic [7:0] b);
    logic [7:0] up;
    logic [4:0] c;
    up = (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
    for (int k = 0; k < 5; k++) begin
      c[k] = cand[k] && (pos < KW_LEN[k]) && (kw_char(3'(k), pos) == up);
    end
    return c;
  endfunction

  // Identifier position saturates at seven.
  function automatic logic [2:0] next_pos(logic [2:0] pos);
    return (pos == 3'd7) ? pos : pos + 3'd1;
  endfunction

  // Lowest surviving keyword whose length matches, else a plain identifier.
  function automatic token_kind_t ident_kind(logic [2:0] pos, logic [4:0] cand);
    token_kind_t r;
    r = KIND_IDENT;
    for (int k = 4; k >= 0; k--) begin
      if (cand[k] && pos == KW_LEN[k]) begin
        r = token_kind_t'(4'(8 + k));
      end
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/sql_keyword_lexer_unit.sv
// Results of a byte are registered in the result queue and reach the master side behind any earlier results.
// One byte per cycle while input ready is high; a byte that causes two results queues both of them,
// and input ready drops when two or more results are queued in the three-entry result queue.
// Reset (rst, synchronous, active high) returns the lexer to idle between tokens with
// the keyword mask full and empties the result queue.
module sql_keyword_lexer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] lexeme_byte
  output logic [8:0] m_tuser,   // [0] lexeme_byte_valid, [1] token_complete,
                                // [5:2] token_kind, [7:6] error_code, [8] statement_finished
  output logic       m_tlast    // last_of_run
);

  sqlkl_pkg::lex_mode_t mode, mode_next;
  logic [2:0] pos, pos_next;
  logic [4:0] cand, cand_next;

  logic [7:0] b;
  logic       eot;
  logic       acc;

  // Result queue, entry 0 faces the output.
  sqlkl_pkg::res_t q [3];
  sqlkl_pkg::res_t q_next [3];
  logic [1:0] cnt, cnt_next;
  logic       pop;
  logic [1:0] cs;
  logic [1:0] add;

  // Classification and keyword tracking of the incoming byte.
  logic                   punct_hit;
  sqlkl_pkg::token_kind_t punct_kind;
  logic [2:0]             adv_pos;
  logic [4:0]             adv_cand;
  logic [4:0]             fresh_cand;

  // What a byte does when it arrives between tokens.
  logic                 st_hit;
  sqlkl_pkg::res_t      st_res;
  sqlkl_pkg::lex_mode_t st_mode;
  logic [2:0]           st_pos;
  logic [4:0]           st_cand;

  // Results of the current byte.
  logic [1:0]      n;
  sqlkl_pkg::res_t r0, r1;

  assign b   = s_tdata;
  assign eot = s_tlast;
  assign acc = s_tvalid && s_tready;

  assign adv_pos    = sqlkl_pkg::next_pos(pos);
  assign adv_cand   = sqlkl_pkg::advance_cand(pos, cand, b);
  assign fresh_cand = sqlkl_pkg::advance_cand(3'd0, sqlkl_pkg::ALL_KEYWORDS, b);

  // One-byte punctuation tokens.
  always_comb begin
    punct_hit  = 1'b1;
    punct_kind = sqlkl_pkg::KIND_STAR;
    case (b)
      8'h2A:   punct_kind = sqlkl_pkg::KIND_STAR;
      8'h2C:   punct_kind = sqlkl_pkg::KIND_COMMA;
      8'h3B:   punct_kind = sqlkl_pkg::KIND_SEMICOLON;
      8'h28:   punct_kind = sqlkl_pkg::KIND_LPAREN;
      8'h29:   punct_kind = sqlkl_pkg::KIND_RPAREN;
      default: punct_hit  = 1'b0;
    endcase
  end

  // Start of a new token from between tokens.
  always_comb begin
    st_hit  = 1'b0;
    st_res  = sqlkl_pkg::make_res(8'h00, 1'b0, 1'b0, sqlkl_pkg::KIND_STAR,
                                  sqlkl_pkg::ERR_NONE);
    st_mode = sqlkl_pkg::MODE_IDLE;
    st_pos  = pos;
    st_cand = cand;
    if (punct_hit) begin
      st_hit = 1'b1;
      st_res = sqlkl_pkg::make_res(b, 1'b1, 1'b1, punct_kind, sqlkl_pkg::ERR_NONE);
    end else if (sqlkl_pkg::is_space(b)) begin
      st_mode = sqlkl_pkg::MODE_IDLE;
    end else if (b == sqlkl_pkg::QUOTE_CH) begin
      st_mode = sqlkl_pkg::MODE_STRING;
      st_hit  = eot;
      st_res  = sqlkl_pkg::make_res(8'h00, 1'b0, 1'b0, sqlkl_pkg::KIND_STAR,
                                    sqlkl_pkg::ERR_OPEN_STRING);
    end else if (sqlkl_pkg::is_digit(b)) begin
      st_mode = sqlkl_pkg::MODE_INTEGER;
      st_hit  = 1'b1;
      st_res  = sqlkl_pkg::make_res(b, 1'b1, eot, sqlkl_pkg::KIND_INTEGER,
                                    sqlkl_pkg::ERR_NONE);
    end else if (sqlkl_pkg::is_ident_start(b)) begin
      st_mode = sqlkl_pkg::MODE_IDENT;
      st_pos  = 3'd1;
      st_cand = fresh_cand;
      st_hit  = 1'b1;
      st_res  = sqlkl_pkg::make_res(b, 1'b1, eot, sqlkl_pkg::ident_kind(3'd1, fresh_cand),
                                    sqlkl_pkg::ERR_NONE);
    end else begin
      st_mode = sqlkl_pkg::MODE_SKIP;
      st_hit  = 1'b1;
      st_res  = sqlkl_pkg::make_res(8'h00, 1'b0, 1'b0, sqlkl_pkg::KIND_STAR,
                                    sqlkl_pkg::ERR_INVALID_CHAR);
    end
  end

  // Results caused by the current byte.
  always_comb begin
    n  = 2'd0;
    r0 = sqlkl_pkg::make_res(8'h00, 1'b0, 1'b0, sqlkl_pkg::KIND_STAR, sqlkl_pkg::ERR_NONE);
    r1 = r0;
    case (mode)
      sqlkl_pkg::MODE_STRING: begin
        n = 2'd1;
        if (b == sqlkl_pkg::QUOTE_CH) begin
          r0 = sqlkl_pkg::make_res(8'h00, 1'b0, 1'b1, sqlkl_pkg::KIND_STRING,
                                   sqlkl_pkg::ERR_NONE);
        end else begin
          r0 = sqlkl_pkg::make_res(b, 1'b1, 1'b0, sqlkl_pkg::KIND_STAR, sqlkl_pkg::ERR_NONE);
          if (eot) begin
            r1 = sqlkl_pkg::make_res(8'h00, 1'b0, 1'b0, sqlkl_pkg::KIND_STAR,
                                     sqlkl_pkg::ERR_OPEN_STRING);
            n  = 2'd2;
          end
        end
      end
      sqlkl_pkg::MODE_INTEGER: begin
        if (sqlkl_pkg::is_digit(b)) begin
          r0 = sqlkl_pkg::make_res(b, 1'b1, eot, sqlkl_pkg::KIND_INTEGER, sqlkl_pkg::ERR_NONE);
          n  = 2'd1;
        end else begin
          r0 = sqlkl_pkg::make_res(8'h00, 1'b0, 1'b1, sqlkl_pkg::KIND_INTEGER,
                                   sqlkl_pkg::ERR_NONE);
          r1 = st_res;
          n  = st_hit ? 2'd2 : 2'd1;
        end
      end
      sqlkl_pkg::MODE_IDENT: begin
        if (sqlkl_pkg::is_ident_part(b)) begin
          r0 = sqlkl_pkg::make_res(b, 1'b1, eot, sqlkl_pkg::ident_kind(adv_pos, adv_cand),
                                   sqlkl_pkg::ERR_NONE);
          n  = 2'd1;
        end else begin
          r0 = sqlkl_pkg::make_res(8'h00, 1'b0, 1'b1, sqlkl_pkg::ident_kind(pos, cand),
                                   sqlkl_pkg::ERR_NONE);
          r1 = st_res;
          n  = st_hit ? 2'd2 : 2'd1;
        end
      end
      sqlkl_pkg::MODE_SKIP: begin
        n = 2'd0;
      end
      default: begin
        r0 = st_res;
        n  = {1'b0, st_hit};
      end
    endcase

    // An end of statement always yields at least one result.
    if (eot && n == 2'd0) begin
      n = 2'd1;
    end

    // Tag the final result of the byte.
    if (n == 2'd2) begin
      r1.last_of_run        = 1'b1;
      r1.statement_finished = eot;
    end else begin
      r0.last_of_run        = 1'b1;
      r0.statement_finished = eot;
    end
  end

  // Next lexer state.
  always_comb begin
    mode_next = mode;
    pos_next  = pos;
    cand_next = cand;
    case (mode)
      sqlkl_pkg::MODE_STRING: begin
        if (b == sqlkl_pkg::QUOTE_CH) begin
          mode_next = sqlkl_pkg::MODE_IDLE;
        end
      end
      sqlkl_pkg::MODE_INTEGER: begin
        if (!sqlkl_pkg::is_digit(b)) begin
          mode_next = st_mode;
          pos_next  = st_pos;
          cand_next = st_cand;
        end
      end
      sqlkl_pkg::MODE_IDENT: begin
        if (sqlkl_pkg::is_ident_part(b)) begin
          pos_next  = adv_pos;
          cand_next = adv_cand;
        end else begin
          mode_next = st_mode;
          pos_next  = st_pos;
          cand_next = st_cand;
        end
      end
      sqlkl_pkg::MODE_SKIP: begin
        mode_next = mode;
      end
      default: begin
        mode_next = st_mode;
        pos_next  = st_pos;
        cand_next = st_cand;
      end
    endcase
    if (eot) begin
      mode_next = sqlkl_pkg::MODE_IDLE;
      pos_next  = 3'd0;
      cand_next = sqlkl_pkg::ALL_KEYWORDS;
    end
  end

  // Queue update: shift out on a transfer, then append this byte's results.
  assign pop = (cnt != 2'd0) && m_tready;
  assign cs  = cnt - {1'b0, pop};
  assign add = acc ? n : 2'd0;

  always_comb begin
    q_next[0] = pop ? q[1] : q[0];
    q_next[1] = pop ? q[2] : q[1];
    q_next[2] = q[2];
    for (int i = 0; i < 3; i++) begin
      if (add != 2'd0 && 2'(i) == cs) begin
        q_next[i] = r0;
      end
      if (add == 2'd2 && 2'(i) == cs + 2'd1) begin
        q_next[i] = r1;
      end
    end
    cnt_next = cs + add;
  end

  // State and queue registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sqlkl_pkg::MODE_IDLE;
      pos  <= 3'd0;
      cand <= sqlkl_pkg::ALL_KEYWORDS;
      cnt  <= 2'd0;
    end else begin
      if (acc) begin
        mode <= mode_next;
        pos  <= pos_next;
        cand <= cand_next;
      end
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q[i] <= q_next[i];
    end
  end

  // Ports.
  assign s_tready = (cnt <= 2'd1);
  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = q[0].lexeme_byte;
  assign m_tuser  = {q[0].statement_finished, q[0].error_code, q[0].token_kind,
                     q[0].token_complete, q[0].lexeme_byte_valid};
  assign m_tlast  = q[0].last_of_run;

  // An accepted end-of-statement byte leaves the lexer in its reset state.
  a_eot_resets: assert property (@(posedge clk) disable iff (rst)
    acc && s_tlast |=> mode == sqlkl_pkg::MODE_IDLE && pos == 3'd0 &&
                       cand == sqlkl_pkg::ALL_KEYWORDS)
    else $error("lexer state not cleared after end of statement");

  // While skipping, bytes that do not end the statement add no results.
  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    acc && mode == sqlkl_pkg::MODE_SKIP && !s_tlast |=> cnt == $past(cs))
    else $error("result queued while skipping a bad statement");

  // Inside an identifier at least one character has been counted.
  a_ident_pos: assert property (@(posedge clk) disable iff (rst)
    mode == sqlkl_pkg::MODE_IDENT |-> pos != 3'd0)
    else $error("identifier mode with zero position");

  // The result that closes a statement is always the last one of its byte.
  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && q[0].statement_finished |-> q[0].last_of_run)
    else $error("statement end on a result that is not last of its byte");

endmodule
